// File: rtl/dag_check_topological_sort_top_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef DAG_CHECK_TOPOLOGICAL_SORT_TOP_MACROS_SVH
`define DAG_CHECK_TOPOLOGICAL_SORT_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold on every clock edge outside reset
`define DAGTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication
`define DAGTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define DAGTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DAGTS_ASSERT(lbl, prop, msg)
`define DAGTS_ASSERT_IMP(lbl, ante, cons, msg)
`define DAGTS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/dagts_pkg.sv
`timescale 1ns / 1ps

package dagts_pkg;

    // Storage geometry, fixed by the 32-bit adjacency row
    localparam int DAGTS_NV           = 32;
    localparam int DAGTS_VW           = 5;
    localparam int DAGTS_CW           = 6;
    localparam int DAGTS_MAX_VERTICES = 32;

    typedef logic [DAGTS_VW-1:0] vtx_t;
    typedef logic [DAGTS_CW-1:0] cnt_t;
    typedef logic [DAGTS_NV-1:0] row_t;
    typedef logic [DAGTS_NV-1:0][DAGTS_VW-1:0] fin_vec_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_CHECK,
        ST_EMIT
    } dagts_state_t;

    // Start command and vertex count handed to a worker unit
    typedef struct packed {
        logic go;
        cnt_t count;
    } unit_ctl_t;

    // Priority encoder: index of the lowest set bit (0 for an empty word)
    function automatic vtx_t lowest_set(input row_t w);
        vtx_t k;
        k = '0;
        for (int i = DAGTS_NV - 1; i >= 0; i--)
        begin
            if (w[i])
                k = DAGTS_VW'(i);
        end
        return k;
    endfunction

endpackage

// File: rtl/dagts_lane.sv
`timescale 1ns / 1ps

// One edge-check lane: flags edge src->dst whose finish order is wrong
module dagts_lane (
    input  logic           edge_bit,
    input  dagts_pkg::vtx_t fin_src,
    input  dagts_pkg::vtx_t fin_dst,
    output logic           hit
);
    import dagts_pkg::*;

    assign hit = edge_bit && (fin_src <= fin_dst);

endmodule

// File: rtl/dagts_check.sv
`timescale 1ns / 1ps

// Cycle check: one source row per cycle, all destinations in parallel lanes,
// lane hits registered and merged into the acyclic flag in the following cycle.
module dagts_check (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dagts_pkg::unit_ctl_t ctl,
    input  dagts_pkg::row_t      vmask,
    input  dagts_pkg::row_t      row_data,
    input  dagts_pkg::fin_vec_t  fin,
    output dagts_pkg::vtx_t      row_addr,
    output logic                 done,
    output logic                 acyclic
);
    import dagts_pkg::*;

    logic run_reg,   run_next;
    cnt_t idx_reg,   idx_next;
    row_t hit_reg;
    logic hv_reg,    hv_next;
    logic hlast_reg, hlast_next;
    logic acyc_reg,  acyc_next;
    logic done_reg,  done_next;

    row_t edges;
    row_t hits;
    logic at_end;

    assign row_addr = idx_reg[DAGTS_VW-1:0];
    assign at_end   = (idx_reg == ctl.count - cnt_t'(1));
    assign edges    = row_data & vmask & ~(row_t'(1) << idx_reg[DAGTS_VW-1:0]);

    // Lanes: one comparator per destination vertex
    for (genvar j = 0; j < DAGTS_NV; j++)
    begin : g_lane
        dagts_lane u_lane (
            .edge_bit (edges[j]),
            .fin_src  (fin[idx_reg[DAGTS_VW-1:0]]),
            .fin_dst  (fin[j]),
            .hit      (hits[j])
        );
    end

    // Scan control and merge
    always_comb
    begin
        run_next   = run_reg;
        idx_next   = idx_reg;
        acyc_next  = acyc_reg;
        hv_next    = run_reg;
        hlast_next = run_reg && at_end;
        done_next  = hv_reg && hlast_reg;
        if (hv_reg && (|hit_reg))
            acyc_next = 1'b0;
        if (ctl.go)
        begin
            run_next  = 1'b1;
            idx_next  = '0;
            acyc_next = 1'b1;
        end
        else if (run_reg)
        begin
            idx_next = idx_reg + cnt_t'(1);
            if (at_end)
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            idx_reg   <= '0;
            hv_reg    <= 1'b0;
            hlast_reg <= 1'b0;
            acyc_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            run_reg   <= run_next;
            idx_reg   <= idx_next;
            hv_reg    <= hv_next;
            hlast_reg <= hlast_next;
            acyc_reg  <= acyc_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hits;
    end

    assign done    = done_reg;
    assign acyclic = acyc_reg;

endmodule

// File: rtl/dagts_search.sv
`timescale 1ns / 1ps

`include "dag_check_topological_sort_top_macros.svh"

// Depth-first search with an explicit stack: one push or one pop per cycle.
// Records finish times and fills the order store in reverse finish order.
module dagts_search (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dagts_pkg::unit_ctl_t ctl,
    input  dagts_pkg::row_t      vmask,
    input  dagts_pkg::row_t      row_data,
    input  dagts_pkg::vtx_t      ord_addr,
    output dagts_pkg::vtx_t      row_addr,
    output dagts_pkg::vtx_t      ord_vertex,
    output dagts_pkg::fin_vec_t  fin,
    output logic                 done
);
    import dagts_pkg::*;

    logic run_reg,  run_next;
    cnt_t sp_reg,   sp_next;
    row_t disc_reg, disc_next;
    cnt_t fc_reg,   fc_next;
    logic done_reg, done_next;

    vtx_t     stack_reg [DAGTS_NV];
    fin_vec_t fin_reg;
    vtx_t     ord_reg   [DAGTS_NV];

    vtx_t top_v;
    row_t open_set;
    row_t avail;
    vtx_t pick;
    vtx_t ord_slot;
    logic do_push;
    logic do_pop;

    // Top of stack and neighbour selection
    assign top_v    = stack_reg[sp_reg[DAGTS_VW-1:0] - vtx_t'(1)];
    assign row_addr = top_v;
    assign open_set = row_data & vmask & ~disc_reg;
    assign avail    = vmask & ~disc_reg;
    assign ord_slot = DAGTS_VW'(ctl.count - cnt_t'(1) - fc_reg);

    always_comb
    begin
        if (sp_reg == '0)
            pick = lowest_set(avail);
        else
            pick = lowest_set(open_set);
    end

    always_comb
    begin
        do_push = 1'b0;
        do_pop  = 1'b0;
        if (run_reg)
        begin
            if (sp_reg == '0)
                do_push = (avail != '0);
            else if (open_set != '0)
                do_push = 1'b1;
            else
                do_pop = 1'b1;
        end
    end

    // Control registers
    always_comb
    begin
        run_next  = run_reg;
        sp_next   = sp_reg;
        disc_next = disc_reg;
        fc_next   = fc_reg;
        done_next = 1'b0;
        if (ctl.go)
        begin
            run_next  = 1'b1;
            sp_next   = '0;
            disc_next = '0;
            fc_next   = '0;
        end
        else if (do_push)
        begin
            sp_next         = sp_reg + cnt_t'(1);
            disc_next[pick] = 1'b1;
        end
        else if (do_pop)
        begin
            sp_next = sp_reg - cnt_t'(1);
            fc_next = fc_reg + cnt_t'(1);
        end
        else if (run_reg)
        begin
            // stack empty, nothing left undiscovered
            run_next  = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            sp_reg   <= '0;
            disc_reg <= '0;
            fc_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            sp_reg   <= sp_next;
            disc_reg <= disc_next;
            fc_reg   <= fc_next;
            done_reg <= done_next;
        end
    end

    // Stack, finish times and order store
    always_ff @(posedge clk)
    begin
        if (do_push)
            stack_reg[sp_reg[DAGTS_VW-1:0]] <= pick;
        if (do_pop)
        begin
            fin_reg[top_v]    <= fc_reg[DAGTS_VW-1:0];
            ord_reg[ord_slot] <= top_v;
        end
    end

    assign fin        = fin_reg;
    assign ord_vertex = ord_reg[ord_addr];
    assign done       = done_reg;

    `DAGTS_ASSERT(a_sp_range, sp_reg <= cnt_t'(DAGTS_NV), "stack pointer past depth")
    `DAGTS_ASSERT_IMP(a_done_empty, done_reg, sp_reg == '0, "search ended with stack in use")
    `DAGTS_ASSERT_NXT(a_go_starts, ctl.go, run_reg && (sp_reg == '0) && (fc_reg == '0),
        "search did not start clean")
    `DAGTS_ASSERT_IMP(a_fc_bound, run_reg, fc_reg <= ctl.count, "more finishes than vertices")

endmodule

// File: rtl/dag_check_topological_sort_top.sv
`timescale 1ns / 1ps

// Channel  | Signals                          | Transfer
// ---------+----------------------------------+-----------------------------
// rows in  | start, busy, row_bits, row_last  | edge with start=1, busy=0
// order out| strobe, vertex, acyclic,         | every edge ending a cycle
//          | order_last                       | with strobe=1
//
// Rows load at one per cycle, busy stays low while loading.
// After the row_last transfer busy stays high through search
// (start, one stack push or pop per cycle, end test, done), edge
// check (one source row per cycle, 32 lanes) and emit.
// Results come one per cycle in topological order, each registered and
// shown in the cycle after its emit cycle; the receiver cannot stall.
// Reset clears all control state; stored rows are undefined until loaded.
`include "dag_check_topological_sort_top_macros.svh"

module dag_check_topological_sort_top #(
    parameter int MAX_VERTICES = dagts_pkg::DAGTS_MAX_VERTICES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dagts_pkg::row_t  row_bits,
    input  logic             row_last,
    output logic             strobe,
    output dagts_pkg::vtx_t  vertex,
    output logic             acyclic,
    output logic             order_last
);
    import dagts_pkg::*;

    localparam int VLIMIT = (MAX_VERTICES < DAGTS_NV) ? MAX_VERTICES : DAGTS_NV;

    dagts_state_t state_reg, state_next;

    cnt_t row_pos_reg, row_pos_next;
    cnt_t count_reg,   count_next;
    row_t vmask_reg,   vmask_next;
    logic go_reg,      go_next;
    cnt_t k_reg,       k_next;
    logic strobe_reg,  strobe_next;
    vtx_t vertex_reg;
    logic acyc_reg;
    logic olast_reg;

    row_t adj_reg [DAGTS_NV];

    logic      accept;
    logic      pos_open;
    logic      emit_en;
    logic      emit_end;
    logic      in_check;
    vtx_t      row_addr;
    row_t      row_data;
    unit_ctl_t s_ctl;
    unit_ctl_t c_ctl;
    vtx_t      s_row_addr;
    vtx_t      c_row_addr;
    vtx_t      ord_vertex;
    fin_vec_t  fin;
    logic      s_done;
    logic      c_done;
    logic      c_acyclic;

    assign accept   = start && !busy;
    assign pos_open = (row_pos_reg < cnt_t'(VLIMIT));
    assign emit_end = (k_reg == count_reg - cnt_t'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && row_last)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (s_done)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (c_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_end)
                    state_next = ST_LOAD;
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    // State outputs
    always_comb
    begin
        busy     = 1'b1;
        emit_en  = 1'b0;
        in_check = 1'b0;
        case (state_reg)
            ST_LOAD:   busy     = 1'b0;
            ST_SEARCH: busy     = 1'b1;
            ST_CHECK:  in_check = 1'b1;
            ST_EMIT:   emit_en  = 1'b1;
            default:   busy     = 1'b1;
        endcase
    end

    // Row loading, vertex count and valid mask
    always_comb
    begin
        row_pos_next = row_pos_reg;
        count_next   = count_reg;
        vmask_next   = vmask_reg;
        go_next      = accept && row_last;
        if (accept)
        begin
            if (pos_open)
                row_pos_next = row_pos_reg + cnt_t'(1);
            if (row_last)
            begin
                row_pos_next = '0;
                count_next   = row_pos_reg + (pos_open ? cnt_t'(1) : cnt_t'(0));
                for (int j = 0; j < DAGTS_NV; j++)
                begin
                    vmask_next[j] = (cnt_t'(j) < count_next);
                end
            end
        end
    end

    // Emit counter
    always_comb
    begin
        k_next      = k_reg;
        strobe_next = emit_en;
        if (c_done)
            k_next = '0;
        else if (emit_en)
            k_next = k_reg + cnt_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            row_pos_reg <= '0;
            count_reg   <= '0;
            vmask_reg   <= '0;
            go_reg      <= 1'b0;
            k_reg       <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_pos_reg <= row_pos_next;
            count_reg   <= count_next;
            vmask_reg   <= vmask_next;
            go_reg      <= go_next;
            k_reg       <= k_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Adjacency rows and result payload
    always_ff @(posedge clk)
    begin
        if (accept && pos_open)
            adj_reg[row_pos_reg[DAGTS_VW-1:0]] <= row_bits;
        if (emit_en)
        begin
            vertex_reg <= ord_vertex;
            acyc_reg   <= c_acyclic;
            olast_reg  <= emit_end;
        end
    end

    // Shared row read port
    assign row_addr = in_check ? c_row_addr : s_row_addr;
    assign row_data = adj_reg[row_addr];

    assign s_ctl.go    = go_reg;
    assign s_ctl.count = count_reg;
    assign c_ctl.go    = s_done;
    assign c_ctl.count = count_reg;

    dagts_search u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (s_ctl),
        .vmask      (vmask_reg),
        .row_data   (row_data),
        .ord_addr   (k_reg[DAGTS_VW-1:0]),
        .row_addr   (s_row_addr),
        .ord_vertex (ord_vertex),
        .fin        (fin),
        .done       (s_done)
    );

    dagts_check u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (c_ctl),
        .vmask    (vmask_reg),
        .row_data (row_data),
        .fin      (fin),
        .row_addr (c_row_addr),
        .done     (c_done),
        .acyclic  (c_acyclic)
    );

    assign strobe     = strobe_reg;
    assign vertex     = vertex_reg;
    assign acyclic    = acyc_reg;
    assign order_last = strobe_reg && olast_reg;

    `DAGTS_ASSERT_IMP(a_strobe_src, strobe, $past(state_reg == ST_EMIT),
        "result strobe outside emit phase")
    `DAGTS_ASSERT_NXT(a_last_busy, start && !busy && row_last, busy,
        "final row did not start the search")
    `DAGTS_ASSERT_IMP(a_search_idle, state_reg == ST_LOAD, !s_done && !c_done,
        "worker finished while loading")

endmodule

// File: tb/sv/topo_order_checker.sv
`timescale 1ns / 1ps

module topo_order_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  dagts_pkg::row_t  row_bits,
    input  logic             row_last,
    input  logic             strobe,
    input  dagts_pkg::vtx_t  vertex,
    input  logic             acyclic,
    input  logic             order_last,
    output int               fail_count,
    output int               pending
);

    import dagts_pkg::*;

    // Rows past this position are dropped by the block
    localparam int ROW_LIMIT = (DAGTS_MAX_VERTICES < DAGTS_NV) ? DAGTS_MAX_VERTICES : DAGTS_NV;

    typedef struct packed {
        vtx_t vertex;
        logic acyclic;
        logic order_last;
    } order_entry_t;

    row_t         graph_rows [DAGTS_NV];
    int           row_pos;
    order_entry_t order_expect [$];

    // Depth-first search over the loaded rows; queues the emitted order
    function automatic void sort_graph(input int n);
        row_t         valid;
        row_t         seen;
        row_t         unvisited;
        row_t         edges;
        vtx_t         dfs_stack [DAGTS_NV];
        vtx_t         finish_at [DAGTS_NV];
        vtx_t         topo [DAGTS_NV];
        int           depth;
        int           stamp;
        vtx_t         v;
        vtx_t         next_v;
        logic         no_cycle;
        order_entry_t entry;

        valid = (n >= DAGTS_NV) ? '1 : row_t'((64'd1 << n) - 64'd1);
        seen = '0;
        stamp = 0;
        next_v = '0;
        for (int s = 0; s < n; s++)
        begin
            if (!seen[s])
            begin
                seen[s] = 1'b1;
                dfs_stack[0] = vtx_t'(s);
                depth = 1;
                while (depth > 0)
                begin
                    v = dfs_stack[depth - 1];
                    unvisited = graph_rows[v] & valid & ~seen;
                    if (unvisited != '0 && depth < DAGTS_NV)
                    begin
                        // lowest-numbered open neighbor is pushed
                        for (int b = DAGTS_NV - 1; b >= 0; b--)
                            if (unvisited[b])
                                next_v = vtx_t'(b);
                        seen[next_v] = 1'b1;
                        dfs_stack[depth] = next_v;
                        depth++;
                    end
                    else
                    begin
                        finish_at[v] = vtx_t'(stamp);
                        topo[n - 1 - stamp] = v;
                        stamp++;
                        depth--;
                    end
                end
            end
        end

        // Any non-self edge into a later-finishing vertex means a cycle
        no_cycle = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            edges = graph_rows[i] & valid;
            edges[i] = 1'b0;
            for (int j = 0; j < n; j++)
                if (edges[j] && finish_at[i] <= finish_at[j])
                    no_cycle = 1'b0;
        end

        for (int k = 0; k < n; k++)
        begin
            entry.vertex     = topo[k];
            entry.acyclic    = no_cycle;
            entry.order_last = (k == n - 1);
            order_expect.insert(order_expect.size(), entry);
        end
    endfunction

    // Sample both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        order_entry_t got;
        order_entry_t want;

        if (!rst_n)
        begin
            row_pos = 0;
            order_expect.delete();
            fail_count = 0;
        end
        else
        begin
            // result transfer: compare with the oldest expectation
            if (strobe)
            begin
                got.vertex     = vertex;
                got.acyclic    = acyclic;
                got.order_last = order_last;
                if (order_expect.size() == 0)
                begin
                    $error("unexpected result: vertex %0d acyclic %0b order_last %0b",
                           got.vertex, got.acyclic, got.order_last);
                    fail_count++;
                end
                else
                begin
                    want = order_expect.pop_front();
                    if (got.vertex !== want.vertex)
                    begin
                        $error("vertex: expected %0d, actual %0d", want.vertex, got.vertex);
                        fail_count++;
                    end
                    if (got.acyclic !== want.acyclic)
                    begin
                        $error("acyclic: expected %0b, actual %0b", want.acyclic, got.acyclic);
                        fail_count++;
                    end
                    if (got.order_last !== want.order_last)
                    begin
                        $error("order_last: expected %0b, actual %0b",
                               want.order_last, got.order_last);
                        fail_count++;
                    end
                end
            end

            // row transfer: store, and sort on the closing row
            if (start && !busy)
            begin
                if (row_pos < ROW_LIMIT)
                begin
                    graph_rows[row_pos] = row_bits;
                    row_pos++;
                end
                if (row_last)
                begin
                    sort_graph(row_pos);
                    row_pos = 0;
                end
            end
        end
        pending = order_expect.size();
    end

endmodule

// File: tb/sv/tb_dag_check_topological_sort_top.sv
`timescale 1ns / 1ps

module tb_dag_check_topological_sort_top;

    import dagts_pkg::*;

    localparam int ROW_ITEMS   = 370;
    localparam int DRAIN_WAIT  = 4 * DAGTS_NV + 64;

    typedef enum int {
        SHAPE_FORWARD,
        SHAPE_BACKWARD,
        SHAPE_SPARSE,
        SHAPE_DENSE
    } graph_shape_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    row_t  row_bits;
    logic  row_last;
    logic  strobe;
    vtx_t  vertex;
    logic  acyclic;
    logic  order_last;
    int    fail_count;
    int    pending;
    int    idle_pct;
    int    rows_sent;

    dag_check_topological_sort_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .row_bits   (row_bits),
        .row_last   (row_last),
        .strobe     (strobe),
        .vertex     (vertex),
        .acyclic    (acyclic),
        .order_last (order_last)
    );

    topo_order_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .row_bits   (row_bits),
        .row_last   (row_last),
        .strobe     (strobe),
        .vertex     (vertex),
        .acyclic    (acyclic),
        .order_last (order_last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // One row transfer, preceded by a random idle gap
    task automatic send_row(input row_t bits, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        row_bits <= bits;
        row_last <= last;
        do
            @(posedge clk);
        while (busy);
        rows_sent++;
    endtask

    // Row i of an n-row graph of the given shape
    function automatic row_t graph_row(input graph_shape_t shape, input int i, input int n);
        row_t bits;
        row_t beyond;

        beyond = (n >= DAGTS_NV) ? '0 : ~row_t'((64'd1 << n) - 64'd1);
        case (shape)
            // edges only to higher vertices: acyclic
            SHAPE_FORWARD:  bits = $urandom() & ~row_t'((64'd2 << i) - 64'd1);
            // edges only to lower vertices: acyclic
            SHAPE_BACKWARD: bits = ($urandom() & row_t'((64'd1 << i) - 64'd1))
                                   | ($urandom() & beyond);
            SHAPE_SPARSE:   bits = $urandom() & $urandom() & $urandom();
            default:        bits = $urandom();
        endcase
        if (i < DAGTS_NV && $urandom_range(3) == 0)
            bits[i] = 1'b1;
        return bits;
    endfunction

    task automatic send_graph(input graph_shape_t shape, input int n);
        for (int i = 0; i < n; i++)
            send_row(graph_row(shape, i, n), i == n - 1);
    endtask

    initial
    begin
        int n;
        int graph_idx;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        row_bits  <= '0;
        row_last  <= 1'b0;
        idle_pct  = 27;
        rows_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-row graphs: empty row, and all bits set (self-loop, bits beyond count)
        send_row(32'h0000_0000, 1'b1);
        send_row(32'hFFFF_FFFF, 1'b1);
        // Backward chain with self-loops and bits beyond the count
        send_row(32'hFFFF_FFF1, 1'b0);
        send_row(32'hF000_0003, 1'b0);
        send_row(32'h0000_0002, 1'b0);
        send_row(32'h8000_0005, 1'b1);
        // Three-vertex cycle
        send_row(32'h0000_0002, 1'b0);
        send_row(32'h0000_0004, 1'b0);
        send_row(32'h0000_0001, 1'b1);
        // Single forward edge
        send_row(32'h0000_0002, 1'b0);
        send_row(32'h0000_0000, 1'b1);
        // Diamond
        send_row(32'h0000_0006, 1'b0);
        send_row(32'h0000_0008, 1'b0);
        send_row(32'h0000_0008, 1'b0);
        send_row(32'h0000_0010, 1'b0);
        send_row(32'h0000_0000, 1'b1);

        // Random graphs; every twelfth one at or past the row limit
        graph_idx = 0;
        while (rows_sent < ROW_ITEMS)
        begin
            if (rows_sent >= 2 * ROW_ITEMS / 3)
                idle_pct = 0;
            else if (rows_sent >= ROW_ITEMS / 3)
                idle_pct = 88;
            if (graph_idx % 12 == 5)
                n = DAGTS_NV + $urandom_range(3);
            else
                n = $urandom_range(1, 10);
            send_graph(graph_shape_t'($urandom_range(3)), n);
            graph_idx++;
        end
        start <= 1'b0;

        // Drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
